// ----- rtl/tga_pkg.sv -----
// Shared types and constants for the transpose gather address generator.
`default_nettype none
package tga_pkg;
  localparam int unsigned NUM_AXES = 4;
  localparam int unsigned NUM_REGS = 2 * NUM_AXES;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DIV_STAGES = DATA_W;
  localparam int unsigned DIM_STAGES = DIV_STAGES + 2;

  localparam logic [REG_IDX_W-1:0] REG_OUT_STRIDE_0 = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SRC_STRIDE_0 = REG_IDX_W'(NUM_AXES);

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t num;
    word_t rem;
    word_t quo;
    word_t acc;
  } stage_t;
endpackage
`default_nettype wire

// ----- rtl/tga_cfg.sv -----
// Stride register file written through the configuration port.
`default_nettype none
module tga_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tga_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire tga_pkg::word_t                cfg_wdata,
  output tga_pkg::word_t                     div_stride [tga_pkg::NUM_AXES],
  output tga_pkg::word_t                     src_stride [tga_pkg::NUM_AXES]
);
  import tga_pkg::*;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        div_stride[a] <= word_t'(1);
        src_stride[a] <= (a == NUM_AXES - 1) ? word_t'(1) : word_t'(0);
      end else if (cfg_we) begin
        if (cfg_addr == REG_OUT_STRIDE_0 + REG_IDX_W'(a)) begin
          div_stride[a] <= cfg_wdata;
        end
        if (cfg_addr == REG_SRC_STRIDE_0 + REG_IDX_W'(a)) begin
          src_stride[a] <= cfg_wdata;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tga_pipe.sv -----
// Front end: accepts indices and runs the divide, multiply and add stages.
`default_nettype none
module tga_pipe #(
  parameter int unsigned MAX_DIMS = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire tga_pkg::word_t in_index,
  input  wire tga_pkg::word_t div_stride [tga_pkg::NUM_AXES],
  input  wire tga_pkg::word_t src_stride [tga_pkg::NUM_AXES],
  output logic                res_valid,
  output tga_pkg::word_t      res_index
);
  import tga_pkg::*;

  localparam int unsigned NSTG = MAX_DIMS * DIM_STAGES;

  stage_t               st [NSTG];
  logic    [NSTG-1:0]   vld;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int unsigned P = s % DIM_STAGES;
    localparam int unsigned D = s / DIM_STAGES;
    stage_t prv;
    logic   pv;
    stage_t nxt;

    if (s == 0) begin : g_first
      assign prv = '{num: in_index, rem: '0, quo: '0, acc: '0};
      assign pv  = in_valid;
    end else begin : g_rest
      assign prv = st[s-1];
      assign pv  = vld[s-1];
    end

    if (P < DIV_STAGES) begin : g_div
      logic [DATA_W:0]   t;
      logic [DATA_W-1:0] diff;
      assign t    = {prv.rem, prv.num[DATA_W-1-P]};
      assign diff = t[DATA_W-1:0] - div_stride[D];
      always_comb begin
        nxt = prv;
        if (P == 0) begin
          nxt.quo = '0;
        end
        if (t >= {1'b0, div_stride[D]}) begin
          nxt.rem = diff;
          nxt.quo[DATA_W-1-P] = 1'b1;
        end else begin
          nxt.rem = t[DATA_W-1:0];
        end
      end
    end else if (P == DIV_STAGES) begin : g_mul
      logic [DATA_W-1:0] prod;
      assign prod = prv.quo * src_stride[D];
      always_comb begin
        nxt = prv;
        if (div_stride[D] == '0) begin
          nxt.quo = '0;
          nxt.rem = prv.num;
        end else begin
          nxt.quo = prod;
        end
      end
    end else begin : g_add
      always_comb begin
        nxt     = prv;
        nxt.acc = prv.acc + prv.quo;
        nxt.num = prv.rem;
        nxt.rem = '0;
        nxt.quo = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= nxt;
      end
    end
  end

  assign res_valid = vld[NSTG-1];
  assign res_index = st[NSTG-1].acc;
endmodule
`default_nettype wire

// ----- rtl/tga_fifo.sv -----
// Back end: short result queue that drives the output stream.
`default_nettype none
module tga_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tga_pkg::word_t push_data,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tga_pkg::word_t      out_data
);
  import tga_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  word_t          mem [DEPTH];
  logic  [PW-1:0] wptr;
  logic  [PW-1:0] rptr;
  logic  [CW-1:0] count;
  logic           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign full      = count == CW'(DEPTH);
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/transpose_gather_address.sv -----
// Top level of the transpose gather address generator.
// Each dimension runs 32 divide steps, a multiply and an add, each in its own
// registered stage, and results then pass through the result queue.
// Throughput: one transaction per cycle while the queue has room; the divider
// is fully pipelined. The pipeline holds when the two-entry result queue is full.
// Synchronous reset empties the pipeline and queue and loads the stride resets.
`default_nettype none
module transpose_gather_address #(
  parameter int unsigned MAX_DIMS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tga_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire logic [31:0]                   cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [31:0]                   s_tdata,   // dest_index[31:0]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [31:0]                        m_tdata    // source_index[31:0]
);
  import tga_pkg::*;

  word_t div_stride [NUM_AXES];
  word_t src_stride [NUM_AXES];
  logic  en;
  logic  full;
  logic  res_valid;
  word_t res_index;

  assign en       = !full;
  assign s_tready = en;

  tga_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .div_stride (div_stride),
    .src_stride (src_stride)
  );

  tga_pipe #(.MAX_DIMS(MAX_DIMS)) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .in_index   (s_tdata),
    .div_stride (div_stride),
    .src_stride (src_stride),
    .res_valid  (res_valid),
    .res_index  (res_index)
  );

  tga_fifo #(.DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid && en),
    .push_data (res_index),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );
endmodule
`default_nettype wire

// ----- rtl/tga_checker.sv -----
// Port-level checks for the transpose gather address generator and their binding.
`default_nettype none
module tga_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result transaction shown right after reset.");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("Input not ready right after reset.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result transaction changed.");
endmodule

bind transpose_gather_address tga_checker u_tga_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
